/* rtl/core/ms_pkg.sv */
`default_nettype none

package ms_pkg;

  // Element width and default batch capacity
  localparam int DATA_W   = 32;
  localparam int SIZE_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

`default_nettype wire

/* rtl/core/ms_item_if.sv */
`default_nettype none

interface ms_item_if
  import ms_pkg::*;
();

  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);

endinterface

`default_nettype wire

/* rtl/core/ms_result_if.sv */
`default_nettype none

interface ms_result_if
  import ms_pkg::*;
();

  logic  valid;
  logic  ready;
  data_t value_res;
  logic  last_res;
  logic  dropped;

  modport source (output valid, output value_res, output last_res, output dropped,
                  input ready);
  modport sink   (input valid, input value_res, input last_res, input dropped,
                  output ready);

endinterface

`default_nettype wire

/* rtl/core/ms_ram.sv */
`default_nettype none

module ms_ram
  import ms_pkg::*;
#(
  parameter int DEPTH = SIZE_DEF,
  parameter int AW    = $clog2(SIZE_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire data_t         wdata,
  input  wire logic [AW-1:0] raddr_a,
  input  wire logic [AW-1:0] raddr_b,
  output data_t              rdata_a,
  output data_t              rdata_b
);

  data_t mem [DEPTH];

  // Write one word, read two with registered data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

/* rtl/core/merge_sorter_unit.sv */
`default_nettype none

// Batch merge sorter.
// items: one signed word per handshake; the word with last set closes the
// batch. Up to SIZE words are kept; later words are discarded and the
// dropped flag is raised on every result of that batch.
// results: the batch in ascending order (equal values in arrival order),
// last_res on the final word.
// Loading stores each accepted word in buffer 0. After the closing word, the
// sorter runs ceil(log2(n)) merge passes over n stored words; each pass opens
// with a start state that primes the read ports, then merges one word per
// cycle through a single compare unit that reads two buffer ports and writes
// the other buffer. An output-prepare state primes the read port, then one
// result per cycle while results.ready is high.
// items.ready is high only while the block is loading; it is low from the
// closing word until the final result is taken. A stalled receiver simply
// holds the current result; nothing is lost. Reset empties the batch count
// and the dropped flag; buffer contents need no clearing.
module merge_sorter_unit
  import ms_pkg::*;
#(
  parameter int SIZE = SIZE_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  ms_item_if.sink       items,
  ms_result_if.source   results
);

  localparam int AW = $clog2(SIZE);
  localparam int CW = $clog2(SIZE + 1);
  localparam int EW = CW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_MERGE,
    S_OPREP,
    S_EMIT
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          ovf, ovf_next;
  logic [CW-1:0] n, n_next;
  logic [EW-1:0] w, w_next;
  logic [CW-1:0] i, i_next;
  logic [CW-1:0] j, j_next;
  logic [CW-1:0] k, k_next;
  logic [CW-1:0] mid, mid_next;
  logic [CW-1:0] hi, hi_next;
  logic          src, src_next;

  logic          m0_we, m1_we;
  logic [AW-1:0] m0_waddr;
  data_t         m0_wdata;
  logic [AW-1:0] rd_a, rd_b;
  data_t         r0_a, r0_b, r1_a, r1_b;

  data_t         head_a, head_b, wdata;
  logic          take_l;
  logic [EW-1:0] n_e, hi_e, w2, w4, run_mid, run_hi;
  logic [EW-1:0] run_mid_c, run_hi_c, w2_c, w4_c;

  // Ping and pong buffers; buffer 0 takes the loaded words
  ms_ram #(.DEPTH(SIZE), .AW(AW)) u_ram0 (
    .clk     (clk),
    .we      (m0_we),
    .waddr   (m0_waddr),
    .wdata   (m0_wdata),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .rdata_a (r0_a),
    .rdata_b (r0_b)
  );

  ms_ram #(.DEPTH(SIZE), .AW(AW)) u_ram1 (
    .clk     (clk),
    .we      (m1_we),
    .waddr   (k[AW-1:0]),
    .wdata   (wdata),
    .raddr_a (rd_a),
    .raddr_b (rd_b),
    .rdata_a (r1_a),
    .rdata_b (r1_b)
  );

  // Shared compare unit: pick the left head unless the left run is spent or the right one is smaller
  assign head_a = src ? r1_a : r0_a;
  assign head_b = src ? r1_b : r0_b;
  assign take_l = (i < mid) && (!(j < hi) || (head_a <= head_b));
  assign wdata  = take_l ? head_a : head_b;

  // Run bounds, clipped to the batch length
  assign n_e       = EW'(n);
  assign hi_e      = EW'(hi);
  assign w2        = w << 1;
  assign w4        = w << 2;
  assign run_mid   = hi_e + w;
  assign run_hi    = hi_e + w2;
  assign run_mid_c = (run_mid < n_e) ? run_mid : n_e;
  assign run_hi_c  = (run_hi < n_e) ? run_hi : n_e;
  assign w2_c      = (w2 < n_e) ? w2 : n_e;
  assign w4_c      = (w4 < n_e) ? w4 : n_e;

  // Sequencer next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    ovf_next   = ovf;
    n_next     = n;
    w_next     = w;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    mid_next   = mid;
    hi_next    = hi;
    src_next   = src;
    m0_we      = 1'b0;
    m0_waddr   = k[AW-1:0];
    m0_wdata   = wdata;
    m1_we      = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (items.valid) begin
          src_next = 1'b0;
          // store the word, or drop it when full
          if (cnt < CW'(SIZE)) begin
            m0_we    = 1'b1;
            m0_waddr = cnt[AW-1:0];
            m0_wdata = items.value;
            cnt_next = cnt + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (items.last) begin
            n_next   = cnt_next;
            k_next   = '0;
            i_next   = '0;
            mid_next = CW'(1);
            j_next   = CW'(1);
            hi_next  = CW'(2);
            w_next   = EW'(1);
            state_next = (cnt_next == CW'(1)) ? S_OPREP : S_START;
          end
        end
      end

      S_START: begin
        state_next = S_MERGE;
      end

      S_MERGE: begin
        // write the chosen head into the other buffer
        if (src) begin
          m0_we = 1'b1;
        end else begin
          m1_we = 1'b1;
        end
        if (k + CW'(1) != hi) begin
          // advance within the run
          k_next = k + CW'(1);
          if (take_l) begin
            i_next = i + CW'(1);
          end else begin
            j_next = j + CW'(1);
          end
        end else if (hi != n) begin
          // open the next run of this pass
          k_next   = hi;
          i_next   = hi;
          mid_next = run_mid_c[CW-1:0];
          j_next   = run_mid_c[CW-1:0];
          hi_next  = run_hi_c[CW-1:0];
        end else begin
          // pass done: swap buffers, double the run width
          src_next = !src;
          w_next   = w2;
          k_next   = '0;
          i_next   = '0;
          if (w2 >= n_e) begin
            state_next = S_OPREP;
          end else begin
            mid_next   = w2_c[CW-1:0];
            j_next     = w2_c[CW-1:0];
            hi_next    = w4_c[CW-1:0];
            state_next = S_START;
          end
        end
      end

      S_OPREP: begin
        state_next = S_EMIT;
      end

      S_EMIT: begin
        if (results.ready) begin
          if (k + CW'(1) == n) begin
            cnt_next   = '0;
            ovf_next   = 1'b0;
            state_next = S_IDLE;
          end else begin
            k_next = k + CW'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Read addresses follow the next indices so the registered data lands in the cycle after
    if (state_next == S_OPREP || state_next == S_EMIT) begin
      rd_a = k_next[AW-1:0];
    end else begin
      rd_a = i_next[AW-1:0];
    end
    rd_b = j_next[AW-1:0];
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ovf   <= 1'b0;
      src   <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ovf   <= ovf_next;
      src   <= src_next;
    end
    n   <= n_next;
    w   <= w_next;
    i   <= i_next;
    j   <= j_next;
    k   <= k_next;
    mid <= mid_next;
    hi  <= hi_next;
  end

  // Channel outputs
  assign items.ready       = (state == S_IDLE);
  assign results.valid     = (state == S_EMIT);
  assign results.value_res = head_a;
  assign results.last_res  = (k + CW'(1) == n);
  assign results.dropped   = ovf;

  // Checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(items.ready && results.valid))
    else $error("loading and emitting at once");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.ready && results.last_res |=> items.ready && cnt == '0)
    else $error("block not idle and empty after final word");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(SIZE))
    else $error("word count beyond capacity");

  a_merge_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE |-> (k < hi) && (i <= mid) && (j <= hi) && (hi <= n))
    else $error("merge indices out of run bounds");

endmodule

`default_nettype wire
